[hw/rtl/wpsr_pkg.sv]
// ----------------------------------------------------------------------------
// wpsr_pkg
// Shared types and constants of the window pixel stream to RGB565 converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wpsr_pkg;

   localparam logic [7:0] CMD_COLUMN = 8'h2A;
   localparam logic [7:0] CMD_ROW    = 8'h2B;
   localparam logic [7:0] CMD_WRITE  = 8'h2C;

   localparam logic [15:0] RESET_SCREEN_WIDTH  = 16'd132;
   localparam logic [15:0] RESET_SCREEN_HEIGHT = 16'd162;

   localparam logic [1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_PIXEL_FORMAT  = 2'd2;

   localparam logic [1:0] FMT_RGB332 = 2'd0;
   localparam logic [1:0] FMT_RGB565 = 2'd1;
   localparam logic [1:0] FMT_RGB888 = 2'd2;

   localparam logic       REQ_WINDOW = 1'b0;

   // byte positions within a window transaction
   localparam logic [3:0] WIN_IDX_COL_CMD  = 4'd0;
   localparam logic [3:0] WIN_IDX_XS_HI    = 4'd1;
   localparam logic [3:0] WIN_IDX_XS_LO    = 4'd2;
   localparam logic [3:0] WIN_IDX_XE_HI    = 4'd3;
   localparam logic [3:0] WIN_IDX_XE_LO    = 4'd4;
   localparam logic [3:0] WIN_IDX_ROW_CMD  = 4'd5;
   localparam logic [3:0] WIN_IDX_YS_HI    = 4'd6;
   localparam logic [3:0] WIN_IDX_YS_LO    = 4'd7;
   localparam logic [3:0] WIN_IDX_YE_HI    = 4'd8;
   localparam logic [3:0] WIN_IDX_YE_LO    = 4'd9;
   localparam logic [3:0] WIN_IDX_WR_CMD   = 4'd10;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      KIND_WINDOW,
      KIND_REJECT,
      KIND_PIXEL
   } entry_kind_type;

   // For KIND_PIXEL the RGB565 word travels in x_start.
   typedef struct packed {
      entry_kind_type kind;
      logic [15:0]    x_start;
      logic [15:0]    x_end;
      logic [15:0]    y_start;
      logic [15:0]    y_end;
   } entry_type;

endpackage

[hw/rtl/wpsr_front.sv]
// ----------------------------------------------------------------------------
// wpsr_front
// Accepts request transactions, holds the CSRs, checks window bounds and
// assembles source pixels into RGB565 words for the work queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wpsr_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_type,
   input  logic [15:0]         req_win_x,
   input  logic [15:0]         req_win_y,
   input  logic [15:0]         req_img_width,
   input  logic [15:0]         req_img_height,
   input  logic [7:0]          req_data_byte,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_wdata,
   input  logic                q_full,
   output logic                push_valid,
   output wpsr_pkg::entry_type push_entry
);
   import wpsr_pkg::*;

   logic [15:0] scr_width_ff, scr_width_in;
   logic [15:0] scr_height_ff, scr_height_in;
   logic [1:0]  fmt_ff, fmt_in;
   logic [15:0] partial_ff, partial_in;
   logic [1:0]  phase_ff, phase_in;
   logic        open_ff, open_in;

   logic        accept;
   logic [15:0] x_end;
   logic [15:0] y_end;
   logic        win_ok;

   assign req_stall = q_full;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && !q_full;

   assign x_end  = req_win_x + req_img_width - 16'd1;
   assign y_end  = req_win_y + req_img_height - 16'd1;
   assign win_ok = (x_end < scr_width_ff) && (y_end < scr_height_ff);

   always_comb begin
      scr_width_in  = scr_width_ff;
      scr_height_in = scr_height_ff;
      fmt_in        = fmt_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  scr_width_in  = csr_wdata;
            CSR_SCREEN_HEIGHT: scr_height_in = csr_wdata;
            CSR_PIXEL_FORMAT:  fmt_in        = csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      partial_in         = partial_ff;
      phase_in           = phase_ff;
      open_in            = open_ff;
      push_valid         = 1'b0;
      push_entry.kind    = KIND_PIXEL;
      push_entry.x_start = req_win_x;
      push_entry.x_end   = x_end;
      push_entry.y_start = req_win_y;
      push_entry.y_end   = y_end;
      if (accept) begin
         if (req_type == REQ_WINDOW) begin
            partial_in      = 16'd0;
            phase_in        = 2'd0;
            open_in         = win_ok;
            push_valid      = 1'b1;
            push_entry.kind = win_ok ? KIND_WINDOW : KIND_REJECT;
         end else if (open_ff) begin
            unique case (fmt_ff)
               FMT_RGB332: begin
                  partial_in         = 16'd0;
                  phase_in           = 2'd0;
                  push_valid         = 1'b1;
                  push_entry.x_start = {req_data_byte[7:5], 2'b00,
                                        req_data_byte[4:2], 3'b000,
                                        req_data_byte[1:0], 3'b000};
               end
               FMT_RGB565: begin
                  if (phase_ff == 2'd0) begin
                     partial_in = {req_data_byte, 8'h00};
                     phase_in   = 2'd1;
                  end else begin
                     partial_in         = 16'd0;
                     phase_in           = 2'd0;
                     push_valid         = 1'b1;
                     push_entry.x_start = {partial_ff[15:8], req_data_byte};
                  end
               end
               FMT_RGB888: begin
                  if (phase_ff == 2'd0) begin
                     partial_in = {req_data_byte, 8'h00};
                     phase_in   = 2'd1;
                  end else if (phase_ff == 2'd1) begin
                     partial_in = {partial_ff[15:8], req_data_byte};
                     phase_in   = 2'd2;
                  end else begin
                     partial_in         = 16'd0;
                     phase_in           = 2'd0;
                     push_valid         = 1'b1;
                     push_entry.x_start = {partial_ff[15:11], partial_ff[7:2],
                                           req_data_byte[7:3]};
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scr_width_ff  <= RESET_SCREEN_WIDTH;
         scr_height_ff <= RESET_SCREEN_HEIGHT;
         fmt_ff        <= FMT_RGB332;
         partial_ff    <= 16'd0;
         phase_ff      <= 2'd0;
         open_ff       <= 1'b0;
      end else begin
         scr_width_ff  <= scr_width_in;
         scr_height_ff <= scr_height_in;
         fmt_ff        <= fmt_in;
         partial_ff    <= partial_in;
         phase_ff      <= phase_in;
         open_ff       <= open_in;
      end
   end

endmodule

[hw/rtl/wpsr_queue.sv]
// ----------------------------------------------------------------------------
// wpsr_queue
// Small FIFO of work entries between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wpsr_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  wpsr_pkg::entry_type push_entry,
   output logic                q_full,
   output logic                head_valid,
   output wpsr_pkg::entry_type head_entry,
   input  logic                pop
);
   import wpsr_pkg::*;

   entry_type           entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;

   assign q_full     = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_valid && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[hw/rtl/wpsr_back.sv]
// ----------------------------------------------------------------------------
// wpsr_back
// Walks the head queue entry byte by byte into the registered response port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wpsr_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  wpsr_pkg::entry_type head_entry,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_is_data,
   output logic                rsp_last,
   output logic                rsp_rejected
);
   import wpsr_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       data_ff, data_in;
   logic       last_ff, last_in;
   logic       rej_ff, rej_in;
   logic [3:0] idx_ff, idx_in;
   logic       load;
   logic       entry_done;

   assign load = head_valid && (!valid_ff || !rsp_stall);
   assign pop  = load && entry_done;

   always_comb begin
      byte_in    = 8'h00;
      data_in    = 1'b1;
      rej_in     = 1'b0;
      entry_done = 1'b0;
      unique case (head_entry.kind)
         KIND_REJECT: begin
            data_in    = 1'b0;
            rej_in     = 1'b1;
            entry_done = 1'b1;
         end
         KIND_PIXEL: begin
            entry_done = (idx_ff != 4'd0);
            byte_in    = entry_done ? head_entry.x_start[7:0] : head_entry.x_start[15:8];
         end
         KIND_WINDOW: begin
            unique case (idx_ff)
               WIN_IDX_COL_CMD: begin
                  byte_in = CMD_COLUMN;
                  data_in = 1'b0;
               end
               WIN_IDX_XS_HI:   byte_in = head_entry.x_start[15:8];
               WIN_IDX_XS_LO:   byte_in = head_entry.x_start[7:0];
               WIN_IDX_XE_HI:   byte_in = head_entry.x_end[15:8];
               WIN_IDX_XE_LO:   byte_in = head_entry.x_end[7:0];
               WIN_IDX_ROW_CMD: begin
                  byte_in = CMD_ROW;
                  data_in = 1'b0;
               end
               WIN_IDX_YS_HI:   byte_in = head_entry.y_start[15:8];
               WIN_IDX_YS_LO:   byte_in = head_entry.y_start[7:0];
               WIN_IDX_YE_HI:   byte_in = head_entry.y_end[15:8];
               WIN_IDX_YE_LO:   byte_in = head_entry.y_end[7:0];
               default: begin
                  byte_in    = CMD_WRITE;
                  data_in    = 1'b0;
                  entry_done = 1'b1;
               end
            endcase
         end
         default: begin
            entry_done = 1'b1;
         end
      endcase
      last_in = entry_done;
   end

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = entry_done ? 4'd0 : idx_ff + 4'd1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in;
         data_ff <= data_in;
         last_ff <= last_in;
         rej_ff  <= rej_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 4'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_is_data  = data_ff;
   assign rsp_last     = last_ff;
   assign rsp_rejected = rej_ff;

endmodule

[hw/rtl/window_pixel_stream_to_rgb565.sv]
// ----------------------------------------------------------------------------
// window_pixel_stream_to_rgb565
// Turns window and pixel byte transactions into panel command and RGB565
// data bytes.
// ----------------------------------------------------------------------------
// Usage:
//  req_*: one transaction per window open (req_type 0) or source byte
//    (req_type 1). A window yields 11 bytes (column, row and memory write
//    commands with address bytes) or one rejected byte if out of bounds.
//    A completed source pixel yields two RGB565 bytes, high byte first.
//  rsp_*: one byte per transaction; rsp_last marks the final byte of a
//    request transaction.
//  csr_*: screen width, height and pixel format; always ready. Write only
//    while idle.
//  With the queue empty, a request's entry is written into the work queue
//    and its first byte is then registered onto rsp_*.
//  The back end emits one byte per cycle while rsp_stall is low. Requests
//    are taken every cycle while the four-entry work queue has room;
//    req_stall is the queue full flag.
//  A stalled response holds; the queue absorbs up to four more work
//    entries before req_stall rises.
//  Reset clears the window, pixel phase, queue and output; CSRs return to
//    132 x 162, RGB332.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module window_pixel_stream_to_rgb565 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [15:0] req_win_x,
   input  logic [15:0] req_win_y,
   input  logic [15:0] req_img_width,
   input  logic [15:0] req_img_height,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_is_data,
   output logic        rsp_last,
   output logic        rsp_rejected,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import wpsr_pkg::*;

   logic      q_full;
   logic      push_valid;
   entry_type push_entry;
   logic      head_valid;
   entry_type head_entry;
   logic      pop;

   wpsr_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_win_x      (req_win_x),
      .req_win_y      (req_win_y),
      .req_img_width  (req_img_width),
      .req_img_height (req_img_height),
      .req_data_byte  (req_data_byte),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .q_full         (q_full),
      .push_valid     (push_valid),
      .push_entry     (push_entry)
   );

   wpsr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .q_full     (q_full),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   wpsr_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head_entry   (head_entry),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_is_data  (rsp_is_data),
      .rsp_last     (rsp_last),
      .rsp_rejected (rsp_rejected)
   );

endmodule

[hw/rtl/wpsr_checker.sv]
// ----------------------------------------------------------------------------
// wpsr_checker
// Port-level checks of the window pixel stream converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wpsr_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_is_data,
   input logic       rsp_last,
   input logic       rsp_rejected
);
   import wpsr_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) &&
         $stable(rsp_is_data) && $stable(rsp_last) && $stable(rsp_rejected))
      else $error("stalled transaction changed");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> rsp_last && !rsp_is_data && (rsp_out_byte == 8'h00))
      else $error("malformed rejected transaction");

   a_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_data && !rsp_rejected |->
         (rsp_out_byte == CMD_COLUMN) || (rsp_out_byte == CMD_ROW) ||
         (rsp_out_byte == CMD_WRITE))
      else $error("unknown command byte");

   a_cmd_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_data && !rsp_rejected |->
         (rsp_last == (rsp_out_byte == CMD_WRITE)))
      else $error("last flag on wrong command");

endmodule

bind window_pixel_stream_to_rgb565 wpsr_checker u_wpsr_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_byte (rsp_out_byte),
   .rsp_is_data  (rsp_is_data),
   .rsp_last     (rsp_last),
   .rsp_rejected (rsp_rejected)
);

[tb/sv/wpsr_panel_byte_checker.sv]
// ----------------------------------------------------------------------------
// wpsr_panel_byte_checker
// Watches the request, response and CSR channels of the window pixel stream
// converter, predicts the panel bytes for every request transaction and
// compares each response transaction field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wpsr_panel_byte_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_type,
   input  logic [15:0] req_win_x,
   input  logic [15:0] req_win_y,
   input  logic [15:0] req_img_width,
   input  logic [15:0] req_img_height,
   input  logic [7:0]  req_data_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_is_data,
   input  logic        rsp_last,
   input  logic        rsp_rejected,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          outstanding
);
   import wpsr_pkg::*;

   typedef struct packed {
      logic [7:0] value;
      logic       is_data;
      logic       last;
      logic       rejected;
   } panel_byte_type;

   panel_byte_type panel_bytes_due[$];
   panel_byte_type head;

   logic [15:0] cfg_width;
   logic [15:0] cfg_height;
   logic [1:0]  cfg_format;

   logic [15:0] gathered;
   logic [1:0]  gathered_cnt;
   logic        window_is_open;

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   function automatic void due(input logic [7:0] v, input logic d, input logic l,
                               input logic r);
      panel_byte_type e;
      e.value    = v;
      e.is_data  = d;
      e.last     = l;
      e.rejected = r;
      panel_bytes_due.push_back(e);
      outstanding++;
   endfunction

   function automatic void due_rgb565(input logic [4:0] r5, input logic [5:0] g6,
                                      input logic [4:0] b5);
      due({r5, g6[5:3]}, 1'b1, 1'b0, 1'b0);
      due({g6[2:0], b5}, 1'b1, 1'b1, 1'b0);
   endfunction

   function automatic void predict_window(input logic [15:0] x, input logic [15:0] y,
                                          input logic [15:0] w, input logic [15:0] h);
      logic [15:0] xe;
      logic [15:0] ye;
      xe = x + w - 16'd1;
      ye = y + h - 16'd1;
      gathered     = '0;
      gathered_cnt = '0;
      if (xe >= cfg_width || ye >= cfg_height) begin
         window_is_open = 1'b0;
         due(8'h00, 1'b0, 1'b1, 1'b1);
      end else begin
         due(CMD_COLUMN, 1'b0, 1'b0, 1'b0);
         due(x[15:8], 1'b1, 1'b0, 1'b0);
         due(x[7:0], 1'b1, 1'b0, 1'b0);
         due(xe[15:8], 1'b1, 1'b0, 1'b0);
         due(xe[7:0], 1'b1, 1'b0, 1'b0);
         due(CMD_ROW, 1'b0, 1'b0, 1'b0);
         due(y[15:8], 1'b1, 1'b0, 1'b0);
         due(y[7:0], 1'b1, 1'b0, 1'b0);
         due(ye[15:8], 1'b1, 1'b0, 1'b0);
         due(ye[7:0], 1'b1, 1'b0, 1'b0);
         due(CMD_WRITE, 1'b0, 1'b1, 1'b0);
         window_is_open = 1'b1;
      end
   endfunction

   function automatic void predict_pixel_byte(input logic [7:0] b);
      logic [15:0] pix;
      if (window_is_open) begin
         case (cfg_format)
            FMT_RGB332: begin
               gathered     = '0;
               gathered_cnt = '0;
               due_rgb565({b[7:5], 2'b00}, {b[4:2], 3'b000}, {b[1:0], 3'b000});
            end
            FMT_RGB565: begin
               if (gathered_cnt == 2'd0) begin
                  gathered     = {b, 8'h00};
                  gathered_cnt = 2'd1;
               end else begin
                  pix          = {gathered[15:8], b};
                  gathered     = '0;
                  gathered_cnt = '0;
                  due_rgb565(pix[15:11], pix[10:5], pix[4:0]);
               end
            end
            FMT_RGB888: begin
               if (gathered_cnt == 2'd0) begin
                  gathered     = {b, 8'h00};
                  gathered_cnt = 2'd1;
               end else if (gathered_cnt == 2'd1) begin
                  gathered[7:0] = b;
                  gathered_cnt  = 2'd2;
               end else begin
                  pix          = gathered;
                  gathered     = '0;
                  gathered_cnt = '0;
                  due_rgb565(pix[15:11], pix[7:2], b[7:3]);
               end
            end
            default: ;
         endcase
      end
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         panel_bytes_due.delete();
         outstanding    = 0;
         cfg_width      = RESET_SCREEN_WIDTH;
         cfg_height     = RESET_SCREEN_HEIGHT;
         cfg_format     = FMT_RGB332;
         gathered       = '0;
         gathered_cnt   = '0;
         window_is_open = 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SCREEN_WIDTH:  cfg_width  = csr_wdata;
               CSR_SCREEN_HEIGHT: cfg_height = csr_wdata;
               CSR_PIXEL_FORMAT:  cfg_format = csr_wdata[1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (req_type == REQ_WINDOW)
               predict_window(req_win_x, req_win_y, req_img_width, req_img_height);
            else
               predict_pixel_byte(req_data_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            if (panel_bytes_due.size() == 0) begin
               $error("unexpected response transaction: out_byte 0x%0h", rsp_out_byte);
               fail_count++;
            end else begin
               head = panel_bytes_due.pop_front();
               outstanding--;
               check_field("out_byte", head.value, rsp_out_byte);
               check_field("is_data", head.is_data, rsp_is_data);
               check_field("last", head.last, rsp_last);
               check_field("rejected", head.rejected, rsp_rejected);
            end
         end
      end
   end

endmodule

[tb/sv/tb_window_pixel_stream_to_rgb565.sv]
// ----------------------------------------------------------------------------
// tb_window_pixel_stream_to_rgb565
// Drives window and pixel byte transactions plus CSR writes into the
// converter: a directed pass over bounds, wrap and format corner cases, then
// random window bursts across several screen sizes, formats and idle/stall
// mixes. The checker beside the block scores every response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_window_pixel_stream_to_rgb565;
   import wpsr_pkg::*;

   localparam logic       REQ_PIXEL  = 1'b1;
   localparam logic [1:0] FMT_UNUSED = 2'd3;
   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam int         LIMIT      = 200000;
   localparam int         BLOCK_ITEMS = 14;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_type = REQ_WINDOW;
   logic [15:0] req_win_x = '0;
   logic [15:0] req_win_y = '0;
   logic [15:0] req_img_width = '0;
   logic [15:0] req_img_height = '0;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_is_data;
   logic        rsp_last;
   logic        rsp_rejected;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   int fail_count;
   int outstanding;
   int cycles = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int counted = 0;

   logic [15:0] tb_width  = RESET_SCREEN_WIDTH;
   logic [15:0] tb_height = RESET_SCREEN_HEIGHT;

   window_pixel_stream_to_rgb565 DUT (.*);

   wpsr_panel_byte_checker panel_check (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) rsp_stall <= ($urandom_range(99, 0) < stall_pct);

   task automatic send_item(input logic kind, input logic [15:0] x, input logic [15:0] y,
                            input logic [15:0] w, input logic [15:0] h,
                            input logic [7:0] data);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_win_x      <= x;
      req_win_y      <= y;
      req_img_width  <= w;
      req_img_height <= h;
      req_data_byte  <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      counted++;
   endtask

   task automatic win(input logic [15:0] x, input logic [15:0] y, input logic [15:0] w,
                      input logic [15:0] h);
      send_item(REQ_WINDOW, x, y, w, h, 8'($urandom));
   endtask

   task automatic pix(input logic [7:0] b);
      send_item(REQ_PIXEL, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), b);
   endtask

   // sender holds off until every predicted byte has been seen
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (outstanding == 0);
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic configure(input logic [15:0] w, input logic [15:0] h,
                            input logic [1:0] fmt, input bit poke_unused);
      drain();
      // pixel bytes that yield nothing are never pushed into the work queue
      repeat (8) @(posedge clock);
      if (poke_unused)
         write_reg(CSR_UNUSED, 16'($urandom));
      write_reg(CSR_SCREEN_WIDTH, w);
      write_reg(CSR_SCREEN_HEIGHT, h);
      write_reg(CSR_PIXEL_FORMAT, {14'($urandom), fmt});
      csr_valid <= 1'b0;
      tb_width  = w;
      tb_height = h;
   endtask

   function automatic logic [15:0] rand_extent();
      case ($urandom_range(4, 0))
         0:       return 16'hFFFF;
         1:       return 16'd1;
         2:       return 16'($urandom_range(300, 1));
         default: return 16'($urandom_range(65535, 1));
      endcase
   endfunction

   function automatic logic [1:0] rand_format();
      if ($urandom_range(7, 0) == 0)
         return FMT_UNUSED;
      return 2'($urandom_range(2, 0));
   endfunction

   task automatic fitted_window();
      int wi;
      int hi;
      int x;
      int y;
      int w;
      int h;
      wi = tb_width;
      hi = tb_height;
      if (wi == 0 || hi == 0) begin
         win(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
         x = $urandom_range(wi - 1, 0);
         y = $urandom_range(hi - 1, 0);
         w = ($urandom_range(3, 0) == 0) ? wi - x : $urandom_range(wi - x, 1);
         h = ($urandom_range(3, 0) == 0) ? hi - y : $urandom_range(hi - y, 1);
         win(16'(x), 16'(y), 16'(w), 16'(h));
      end
   endtask

   task automatic random_step();
      int pick;
      int n;
      pick = $urandom_range(99, 0);
      if (pick < 5)
         drain();
      if (pick < 65) begin
         fitted_window();
         n = $urandom_range(10, 0);
         repeat (n) pix(8'($urandom));
      end else if (pick < 85) begin
         win(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
         n = $urandom_range(3, 1);
         repeat (n) pix(8'($urandom));
      end
   endtask

   initial begin
      int target;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset geometry 132 x 162, rgb332
      pix(8'hFF);
      win(16'd0, 16'd0, 16'd132, 16'd162);
      pix(8'h00);
      pix(8'hFF);
      pix(8'hA5);
      win(16'd0, 16'd0, 16'd133, 16'd1);
      pix(8'h5A);
      win(16'hFFFF, 16'hFFFF, 16'd2, 16'd2);
      win(16'd0, 16'd0, 16'd0, 16'd0);
      win(16'd131, 16'd161, 16'd1, 16'd1);

      configure(16'hFFFF, 16'hFFFF, FMT_RGB565, 1'b1);
      win(16'hFFFE, 16'h8000, 16'd1, 16'h7FFF);
      pix(8'hFF);
      pix(8'hFF);
      pix(8'h12);
      pix(8'h34);
      pix(8'hAB);
      // format switches with a pixel half gathered
      configure(16'hFFFF, 16'hFFFF, FMT_RGB888, 1'b0);
      pix(8'hCD);
      pix(8'hEF);
      pix(8'h00);
      pix(8'hFF);
      configure(16'hFFFF, 16'hFFFF, FMT_RGB565, 1'b0);
      pix(8'h80);
      pix(8'h77);
      configure(16'hFFFF, 16'hFFFF, FMT_RGB332, 1'b0);
      pix(8'h3C);
      configure(16'd0, 16'd0, FMT_UNUSED, 1'b0);
      pix(8'h11);
      win(16'd0, 16'd0, 16'd1, 16'd1);

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 53; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 53; end
            default: begin send_idle_pct = 35; stall_pct = 35; end
         endcase
         for (int blk = 0; blk < 2; blk++) begin
            configure(rand_extent(), rand_extent(), rand_format(), 1'b0);
            target = counted + BLOCK_ITEMS;
            while (counted < target) random_step();
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
